@@ rtl/core/idro_pkg.sv @@
// Shared types and constants for the input debouncer with remote override.
// Used by input_debounce_with_remote_override_core; depends on nothing.
`timescale 1ns / 1ps

package idro_pkg;

	// Fixed field widths
	localparam int unsigned PIN_W    = 8;
	localparam int unsigned MASK_W   = 8;
	localparam int unsigned CNT_W    = 8;
	localparam int unsigned WORD_W   = 32;
	localparam int unsigned TIME_W   = 64;
	localparam int unsigned CFG_IDX_W = 2;

	// Default channel count
	localparam int unsigned CHANNELS_DEF = 8;

	// Register reset values
	localparam logic [CNT_W-1:0]  DEBOUNCE_RST   = 8'd3;
	localparam logic              ACTIVE_LOW_RST = 1'b1;
	localparam logic [WORD_W-1:0] STALE_RST      = 32'd1000000;

	// Item kinds
	typedef enum logic {
		OP_TICK    = 1'b0,
		OP_PUBLISH = 1'b1
	} op_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEBOUNCE_TICKS = 2'd0,
		CFG_ACTIVE_LOW     = 2'd1,
		CFG_STALE_LIMIT    = 2'd2
	} cfg_reg_t;

	// One remote input image
	typedef struct packed {
		logic [WORD_W-1:0] seq;
		logic [WORD_W-1:0] mask;
		logic [TIME_W-1:0] rx_time;
	} image_t;

	// Statistics block
	typedef struct packed {
		logic [WORD_W-1:0] last_age;
		logic [WORD_W-1:0] max_age;
		logic [WORD_W-1:0] missed;
		logic [WORD_W-1:0] stale;
		logic [WORD_W-1:0] consumed;
		logic [WORD_W-1:0] adopted_seq;
		logic [WORD_W-1:0] last_mask;
		logic              active;
	} stats_t;

endpackage

@@ rtl/core/input_debounce_with_remote_override_core.sv @@
// Top level: input debouncer with remote image override, single-pass datapath.
// Depends on idro_pkg.
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// -------   -----------------------   ---------------------------------------------
// input     in_valid / in_ready       operation, pin_levels, now_us, remote_seq,
//                                     remote_mask, remote_rx_time
// result    out_valid / out_ready     debounced_mask ... last_remote_mask
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A request is captured in an input register, then combinational logic (debounce,
// 64-bit age subtract and compares) updates the state and loads the result register.
// out_valid rises when the request moves from the input register into the result register.
// One request per cycle is taken while out_ready stays high.
// Reset clears the state and valid flags to zero and loads register defaults; cfg_ready is always high.
// When the result is not taken, the input register holds and in_ready drops.

module input_debounce_with_remote_override_core #(
	parameter int unsigned CHANNELS = idro_pkg::CHANNELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input requests
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          operation,
	input  logic [idro_pkg::PIN_W-1:0]    pin_levels,
	input  logic [idro_pkg::TIME_W-1:0]   now_us,
	input  logic [idro_pkg::WORD_W-1:0]   remote_seq,
	input  logic [idro_pkg::WORD_W-1:0]   remote_mask,
	input  logic [idro_pkg::TIME_W-1:0]   remote_rx_time,
	// results
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [idro_pkg::MASK_W-1:0]   debounced_mask,
	output logic [idro_pkg::MASK_W-1:0]   active_raw_mask,
	output logic                          remote_active,
	output logic [idro_pkg::WORD_W-1:0]   last_age,
	output logic [idro_pkg::WORD_W-1:0]   max_age,
	output logic [idro_pkg::WORD_W-1:0]   missed_updates,
	output logic [idro_pkg::WORD_W-1:0]   stale_events,
	output logic [idro_pkg::WORD_W-1:0]   consumed_images,
	output logic [idro_pkg::WORD_W-1:0]   consumed_sequence,
	output logic [idro_pkg::WORD_W-1:0]   tick_total,
	output logic [idro_pkg::WORD_W-1:0]   last_remote_mask,
	// configuration writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [idro_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [idro_pkg::WORD_W-1:0]   cfg_data
);

	import idro_pkg::*;

	// Configuration registers
	logic [CNT_W-1:0]  debounce_ticks_q;
	logic              active_low_q;
	logic [WORD_W-1:0] stale_limit_q;

	// Input stage
	logic              valid_s1;
	logic              op_s1;
	logic [PIN_W-1:0]  pins_s1;
	logic [TIME_W-1:0] now_s1;
	image_t            img_s1;
	logic              advance;

	// Architectural state
	logic [CHANNELS-1:0] raw_q;
	logic [CHANNELS-1:0] cand_q;
	logic [CHANNELS-1:0] deb_q;
	logic [CNT_W-1:0]    cnt_q [CHANNELS];
	image_t              pending_q;
	image_t              active_img_q;
	logic [WORD_W-1:0]   pub_gen_q;
	logic [WORD_W-1:0]   cons_gen_q;
	logic [WORD_W-1:0]   ticks_q;
	stats_t              stats_q;

	// Next-state values
	logic [CHANNELS-1:0] raw_n;
	logic [CHANNELS-1:0] cand_n;
	logic [CHANNELS-1:0] deb_n;
	logic [CNT_W-1:0]    cnt_n [CHANNELS];
	image_t              pending_n;
	image_t              active_img_n;
	logic [WORD_W-1:0]   pub_gen_n;
	logic [WORD_W-1:0]   cons_gen_n;
	logic [WORD_W-1:0]   ticks_n;
	stats_t              stats_n;

	// Helpers for the tick path
	logic [WORD_W-1:0]   pins_ext;
	logic [WORD_W-1:0]   cons_plus1;
	logic [TIME_W:0]     age_diff;
	logic [WORD_W-1:0]   age32;
	logic [WORD_W-1:0]   deb_ext;
	logic [WORD_W-1:0]   raw_ext;

	// Result register
	logic              valid_s2;
	logic [MASK_W-1:0] deb_mask_s2;
	logic [MASK_W-1:0] raw_mask_s2;
	logic [WORD_W-1:0] ticks_s2;
	stats_t            stats_s2;

	// Handshakes
	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;

	// Configuration writes; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q <= DEBOUNCE_RST;
			active_low_q     <= ACTIVE_LOW_RST;
			stale_limit_q    <= STALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DEBOUNCE_TICKS: debounce_ticks_q <= cfg_data[CNT_W-1:0];
				CFG_ACTIVE_LOW:     active_low_q     <= cfg_data[0];
				CFG_STALE_LIMIT:    stale_limit_q    <= cfg_data;
				default:            ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1        <= operation;
			pins_s1      <= pin_levels;
			now_s1       <= now_us;
			img_s1.seq     <= remote_seq;
			img_s1.mask    <= remote_mask;
			img_s1.rx_time <= remote_rx_time;
		end
	end

	// Shared tick arithmetic
	assign pins_ext   = WORD_W'(pins_s1);
	assign cons_plus1 = cons_gen_q + 1'b1;

	// Next-state logic for one request
	always_comb begin
		raw_n        = raw_q;
		cand_n       = cand_q;
		deb_n        = deb_q;
		cnt_n        = cnt_q;
		pending_n    = pending_q;
		active_img_n = active_img_q;
		pub_gen_n    = pub_gen_q;
		cons_gen_n   = cons_gen_q;
		ticks_n      = ticks_q;
		stats_n      = stats_q;
		age_diff     = '0;
		age32        = '0;

		if (op_s1 == OP_PUBLISH) begin
			pending_n = img_s1;
			pub_gen_n = pub_gen_q + 1'b1;
		end else begin
			// Per-channel debounce; channels past the pins read level 0
			for (int i = 0; i < CHANNELS; i++) begin
				raw_n[i] = pins_ext[i] ^ active_low_q;
				if (raw_n[i] == cand_q[i]) begin
					if (cnt_q[i] < debounce_ticks_q) begin
						cnt_n[i] = cnt_q[i] + 1'b1;
					end
					if (cnt_n[i] >= debounce_ticks_q) begin
						deb_n[i] = raw_n[i];
					end
				end else begin
					cand_n[i] = raw_n[i];
					cnt_n[i]  = CNT_W'(1);
				end
			end

			// Adopt a newer published image
			if (pub_gen_q != cons_gen_q) begin
				active_img_n = pending_q;
				if ((pub_gen_q > cons_plus1) && (cons_gen_q != '0)) begin
					stats_n.missed = stats_q.missed + (pub_gen_q - cons_plus1);
				end
				cons_gen_n           = pub_gen_q;
				stats_n.consumed     = stats_q.consumed + 1'b1;
				stats_n.adopted_seq  = pending_q.seq;
				stats_n.last_mask    = pending_q.mask;
			end

			// Freshness check and override
			age_diff = {1'b0, now_s1} - {1'b0, active_img_n.rx_time};
			if (age_diff[TIME_W]) begin
				age32 = '0;
			end else if (age_diff[TIME_W-1:WORD_W] != '0) begin
				age32 = '1;
			end else begin
				age32 = age_diff[WORD_W-1:0];
			end

			if (active_img_n.rx_time == '0) begin
				stats_n.active = 1'b0;
			end else begin
				stats_n.last_age = age32;
				if (age32 > stale_limit_q) begin
					stats_n.active = 1'b0;
					stats_n.stale  = stats_q.stale + 1'b1;
				end else begin
					stats_n.active    = 1'b1;
					stats_n.last_mask = active_img_n.mask;
					if (age32 > stats_q.max_age) begin
						stats_n.max_age = age32;
					end
					for (int i = 0; i < CHANNELS; i++) begin
						raw_n[i]  = active_img_n.mask[i];
						cand_n[i] = active_img_n.mask[i];
						deb_n[i]  = active_img_n.mask[i];
						cnt_n[i]  = debounce_ticks_q;
					end
				end
			end

			ticks_n = ticks_q + 1'b1;
		end
	end

	// State update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q        <= '0;
			cand_q       <= '0;
			deb_q        <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				cnt_q[i] <= '0;
			end
			pending_q    <= '0;
			active_img_q <= '0;
			pub_gen_q    <= '0;
			cons_gen_q   <= '0;
			ticks_q      <= '0;
			stats_q      <= '0;
		end else if (advance) begin
			raw_q        <= raw_n;
			cand_q       <= cand_n;
			deb_q        <= deb_n;
			cnt_q        <= cnt_n;
			pending_q    <= pending_n;
			active_img_q <= active_img_n;
			pub_gen_q    <= pub_gen_n;
			cons_gen_q   <= cons_gen_n;
			ticks_q      <= ticks_n;
			stats_q      <= stats_n;
		end
	end

	// Channel masks cut to the output width
	assign deb_ext = WORD_W'(deb_n);
	assign raw_ext = WORD_W'(raw_n);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			deb_mask_s2 <= deb_ext[MASK_W-1:0];
			raw_mask_s2 <= raw_ext[MASK_W-1:0];
			ticks_s2    <= ticks_n;
			stats_s2    <= stats_n;
		end
	end

	// Output ports
	assign out_valid         = valid_s2;
	assign debounced_mask    = deb_mask_s2;
	assign active_raw_mask   = raw_mask_s2;
	assign remote_active     = stats_s2.active;
	assign last_age          = stats_s2.last_age;
	assign max_age           = stats_s2.max_age;
	assign missed_updates    = stats_s2.missed;
	assign stale_events      = stats_s2.stale;
	assign consumed_images   = stats_s2.consumed;
	assign consumed_sequence = stats_s2.adopted_seq;
	assign tick_total        = ticks_s2;
	assign last_remote_mask  = stats_s2.last_mask;

endmodule
